// ----- rtl/dfq_pkg.sv -----
// Shared types and constants for the deduplicating job queue.
// Depends on nothing; imported by dfq_cell and dedup_fifo_with_keyed_remove.
package dfq_pkg;

	// Fixed widths of the external fields.
	localparam int unsigned FIELD_W  = 32;
	localparam int unsigned CAP_W    = 5;
	localparam int unsigned DEPTH_W  = 5;
	localparam int unsigned STATUS_W = 2;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes.
	typedef enum logic [1:0] {
		KIND_ENQ = 2'd0,
		KIND_DEQ = 2'd1,
		KIND_REM = 2'd2,
		KIND_HAS = 2'd3
	} kind_t;

	// Enqueue status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// Per-transaction control broadcast to every cell.
	typedef struct packed {
		logic remove_en;
		logic load_en;
	} cell_ctl_t;

endpackage

// ----- rtl/dfq_cell.sv -----
// One storage cell of the queue chain: a valid bit, a key and a payload.
// Depends on dfq_pkg; instantiated in a row by dedup_fifo_with_keyed_remove.
module dfq_cell
	import dfq_pkg::*;
#(
	parameter int unsigned KEY_BITS     = 32,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic [KEY_BITS-1:0]     cmp_key,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    lo_valid,
	input  logic                    hi_valid,
	input  logic [KEY_BITS-1:0]     hi_key,
	input  logic [PAYLOAD_BITS-1:0] hi_payload,
	input  logic                    del_in,
	output logic                    del_out,
	output logic                    match,
	output logic                    valid,
	output logic [KEY_BITS-1:0]     key,
	output logic [PAYLOAD_BITS-1:0] payload
);

	logic                    valid_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    load;

	// A valid cell compares its key with the broadcast key.
	assign match = valid_q && (key_q == cmp_key);

	// Once a deletion point is at or below this cell, this cell takes its upper neighbour.
	assign del_out = del_in || (ctl.remove_en && match);

	// Only the lowest empty cell accepts a new entry.
	assign load = ctl.load_en && !valid_q && lo_valid;

	// The valid bit is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (del_out) begin
			valid_q <= hi_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	// Key and payload need no reset; they are only read while valid.
	always_ff @(posedge clk) begin
		if (del_out) begin
			key_q     <= hi_key;
			payload_q <= hi_payload;
		end else if (load) begin
			key_q     <= cmp_key;
			payload_q <= new_payload;
		end
	end

	assign valid   = valid_q;
	assign key     = key_q;
	assign payload = payload_q;

endmodule

// ----- rtl/dedup_fifo_with_keyed_remove.sv -----
// Deduplicating, order-preserving job queue with keyed remove, built as a chain of cells.
// A job passes the input stage, then the result registers, which also drive done.
// One job per cycle unless busy; every cell compares and shifts in the same cycle.
// Reset: the queue empties and the capacity returns to 16; busy is high for one cycle only.
// The receiver cannot stall; done is high for one cycle per result.
// Depends on dfq_pkg and dfq_cell.
module dedup_fifo_with_keyed_remove
	import dfq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH  = 16,
	parameter int unsigned KEY_BITS     = 32,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [FIELD_W-1:0]  job_key,
	input  logic [FIELD_W-1:0]  job_payload,
	input  logic                cap_we,
	input  logic [CAP_W-1:0]    cap_wdata,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic                created,
	output logic                found,
	output logic [FIELD_W-1:0]  out_key,
	output logic [FIELD_W-1:0]  out_payload,
	output logic [DEPTH_W-1:0]  queue_depth
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Input stage.
	logic                    vld_s1;
	kind_t                   kind_s1;
	logic [KEY_BITS-1:0]     key_s1;
	logic [PAYLOAD_BITS-1:0] payload_s1;

	// Control state.
	logic             busy_q;
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	// Result registers.
	logic                done_q;
	logic [STATUS_W-1:0] status_q, status_d;
	logic                created_q, created_d;
	logic                found_q, found_d;
	logic [FIELD_W-1:0]  out_key_q, out_key_d;
	logic [FIELD_W-1:0]  out_payload_q, out_payload_d;

	// Cell chain signals.
	cell_ctl_t               ctl;
	logic [QUEUE_DEPTH:0]    del_chain;
	logic [QUEUE_DEPTH-1:0]  match_vec;
	logic [QUEUE_DEPTH-1:0]  valid_vec;
	logic [KEY_BITS-1:0]     cell_key [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_payload [QUEUE_DEPTH];

	// Decode signals.
	logic             accept;
	logic             key_zero;
	logic             hit;
	logic             full;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cap_eff;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Busy is held for the first cycle after reset only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cap_we) begin
			cap_q <= cap_wdata;
		end
	end

	// Capture an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind_t'(kind);
			key_s1     <= KEY_BITS'(job_key);
			payload_s1 <= PAYLOAD_BITS'(job_payload);
		end
	end

	// Operation decode against the current contents of the chain.
	assign key_zero = (key_s1 == '0);
	assign hit      = |match_vec;
	assign cap_ext  = CMP_W'(cap_q);
	assign cap_eff  = (cap_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_ext;
	assign full     = (CMP_W'(count_q) >= cap_eff);

	always_comb begin
		ctl.remove_en = vld_s1 && (kind_s1 == KIND_REM);
		ctl.load_en   = vld_s1 && (kind_s1 == KIND_ENQ) && !key_zero && !hit && !full;
	end

	// Dequeue deletes at the bottom of the chain; remove is seeded by the matching cell.
	assign del_chain[0] = vld_s1 && (kind_s1 == KIND_DEQ) && valid_vec[0];

	// The row of cells.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                    lo_valid;
		logic                    hi_valid;
		logic [KEY_BITS-1:0]     hi_key;
		logic [PAYLOAD_BITS-1:0] hi_payload;

		if (i == 0) begin : g_lo_first
			assign lo_valid = 1'b1;
		end else begin : g_lo_rest
			assign lo_valid = valid_vec[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_hi_last
			assign hi_valid   = 1'b0;
			assign hi_key     = '0;
			assign hi_payload = '0;
		end else begin : g_hi_rest
			assign hi_valid   = valid_vec[i+1];
			assign hi_key     = cell_key[i+1];
			assign hi_payload = cell_payload[i+1];
		end

		dfq_cell #(
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.cmp_key     (key_s1),
			.new_payload (payload_s1),
			.lo_valid    (lo_valid),
			.hi_valid    (hi_valid),
			.hi_key      (hi_key),
			.hi_payload  (hi_payload),
			.del_in      (del_chain[i]),
			.del_out     (del_chain[i+1]),
			.match       (match_vec[i]),
			.valid       (valid_vec[i]),
			.key         (cell_key[i]),
			.payload     (cell_payload[i])
		);
	end

	// Result fields and the next entry count.
	always_comb begin
		status_d      = ST_OK;
		created_d     = 1'b0;
		found_d       = 1'b0;
		out_key_d     = '0;
		out_payload_d = '0;
		count_d       = count_q;
		case (kind_s1)
			KIND_ENQ: begin
				if (key_zero) begin
					status_d = ST_INVALID;
				end else if (hit) begin
					status_d = ST_OK;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					created_d = 1'b1;
					count_d   = count_q + CNT_W'(1);
				end
			end
			KIND_DEQ: begin
				if (valid_vec[0]) begin
					found_d       = 1'b1;
					out_key_d     = FIELD_W'(cell_key[0]);
					out_payload_d = FIELD_W'(cell_payload[0]);
					count_d       = count_q - CNT_W'(1);
				end
			end
			KIND_REM: begin
				if (hit) begin
					found_d = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			KIND_HAS: begin
				found_d = hit;
			end
			default: begin
				found_d = 1'b0;
			end
		endcase
	end

	// Entry count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= vld_s1;
			if (vld_s1) begin
				count_q <= count_d;
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_q      <= status_d;
			created_q     <= created_d;
			found_q       <= found_d;
			out_key_q     <= out_key_d;
			out_payload_q <= out_payload_d;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign created     = created_q;
	assign found       = found_q;
	assign out_key     = out_key_q;
	assign out_payload = out_payload_q;
	assign queue_depth = DEPTH_W'(count_q);

	// Occupied cells always form a solid block from the bottom of the chain.
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("queue cells are not packed at the bottom");

	// The entry count agrees with the number of occupied cells.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("entry count disagrees with occupied cells");

	// Since keys are unique, at most one cell matches any key.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell holds the same key");

	// A result strobe follows in the cycle after a transaction is processed.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done)
		else $error("result strobe missing after a processed transaction");

	// A newly created entry always reports a good status.
	a_created_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && created) |-> (status == ST_OK))
		else $error("created entry reported with a failing status");

endmodule
